>>> hw/rtl/keyed_counter_table_macros.svh
// Assertion macros used by the keyed counter table checker file.
`ifndef KEYED_COUNTER_TABLE_MACROS_SVH
`define KEYED_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed_counter_table assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed_counter_table assertion failed");

`endif

>>> hw/rtl/kct_pkg.sv
// Package with the widths, codes and interface structs of the keyed counter table.
`default_nettype none

package kct_pkg;

   localparam int ENTRIES = 64;
   localparam int KEY_W   = 32;
   localparam int CNT_W   = 31;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_TAKE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 3'd0,
      ST_NOT_FOUND    = 3'd1,
      ST_INSUFFICIENT = 3'd2,
      ST_FULL         = 3'd3,
      ST_SATURATED    = 3'd4
   } status_type;

   // What the table reports for the key being looked up.
   typedef struct packed {
      logic             hit;
      logic             full;
      logic [CNT_W-1:0] hit_count;
   } lookup_type;

   // How the table changes at the end of the cycle.
   typedef struct packed {
      logic             clear;
      logic             write_hit;
      logic             write_new;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } update_type;

endpackage

`default_nettype wire

>>> hw/rtl/kct_table.sv
// Register table of keys and counts with parallel key match and lowest-free-slot pick.
`default_nettype none

module kct_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [kct_pkg::KEY_W-1:0]    lookup_key,
   output kct_pkg::lookup_type          lookup,
   input  wire  kct_pkg::update_type    update
);
   import kct_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [KEY_W-1:0]   key_ff   [ENTRIES];
   logic [CNT_W-1:0]   count_ff [ENTRIES];

   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_first;
   logic [ENTRIES-1:0] wr_mask;
   logic [CNT_W-1:0]   hit_count;

   // Keys are unique among valid slots, so at most one hit bit is set and
   // an OR over the masked counts selects it.
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == lookup_key);
         hit_count  = hit_count | (hit_vec[i] ? count_ff[i] : '0);
      end
   end

   // Isolate the lowest free slot with the x & -x trick.
   always_comb begin
      free_vec   = ~valid_ff;
      free_first = free_vec & (ENTRIES'(~free_vec) + ENTRIES'(1));
   end

   always_comb begin
      lookup.hit       = |hit_vec;
      lookup.full      = &valid_ff;
      lookup.hit_count = hit_count;
   end

   always_comb begin
      if (update.write_hit) begin
         wr_mask = hit_vec;
      end else if (update.write_new) begin
         wr_mask = free_first;
      end else begin
         wr_mask = '0;
      end
      if (update.clear) begin
         valid_in = '0;
      end else if (update.write_new) begin
         valid_in = valid_ff | free_first;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (wr_mask[i]) begin
            key_ff[i]   <= update.key;
            count_ff[i] <= update.count;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/keyed_counter_table.sv
// Top level of the keyed counter table: input register, table operation, result register.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_kind, req_item_code, req_amount
//   rsp_      out        rsp_valid/rsp_stall  rsp_count, rsp_status
//
// One transaction is accepted per cycle while req_stall is low. A request is held in
// the input register, then the table lookup, the add or subtract and the table update
// happen in one pass into the result register. Updates land in the table at the edge
// that loads the result register, so the next request sees them. Reset clears the
// table's valid bits directly, with no sweep.
// A stall on the result side holds the result and stalls the request side
// only once the input register is also occupied.
`default_nettype none

module keyed_counter_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [kct_pkg::KIND_W-1:0]   req_kind,
   input  wire  [kct_pkg::KEY_W-1:0]    req_item_code,
   input  wire  [kct_pkg::CNT_W-1:0]    req_amount,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [kct_pkg::CNT_W-1:0]    rsp_count,
   output logic [kct_pkg::STAT_W-1:0]   rsp_status
);
   import kct_pkg::*;

   // Input register holding the transaction being worked on.
   logic             s1_valid_ff;
   logic             s1_valid_in;
   kind_type         s1_kind_ff;
   logic [KEY_W-1:0] s1_code_ff;
   logic [CNT_W-1:0] s1_amount_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [CNT_W-1:0] rsp_count_in;
   status_type       rsp_status_ff;
   status_type       rsp_status_in;

   logic             req_accept;
   logic             advance;
   logic             commit;

   lookup_type       lookup;
   update_type       update;
   update_type       update_raw;

   logic [CNT_W:0]   sum;
   logic [CNT_W-1:0] diff;

   // The result register can take a new result when it is empty or its
   // current result leaves in this cycle.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign commit     = s1_valid_ff && advance;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= kind_type'(req_kind);
         s1_code_ff   <= req_item_code;
         s1_amount_ff <= req_amount;
      end
      if (commit) begin
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   kct_table u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (s1_code_ff),
      .lookup     (lookup),
      .update     (update)
   );

   // The sum carries one extra bit so an overflow past the count range is
   // seen and saturated; the difference is only used when it cannot wrap.
   assign sum  = {1'b0, lookup.hit_count} + {1'b0, s1_amount_ff};
   assign diff = lookup.hit_count - s1_amount_ff;

   always_comb begin
      update_raw       = '0;
      update_raw.key   = s1_code_ff;
      update_raw.count = '0;
      rsp_count_in     = '0;
      rsp_status_in    = ST_OK;
      case (s1_kind_ff)
         KIND_ADD: begin
            if (lookup.hit) begin
               update_raw.write_hit = 1'b1;
               if (sum[CNT_W]) begin
                  rsp_count_in  = CNT_MAX;
                  rsp_status_in = ST_SATURATED;
               end else begin
                  rsp_count_in = sum[CNT_W-1:0];
               end
               update_raw.count = rsp_count_in;
            end else if (lookup.full) begin
               rsp_status_in = ST_FULL;
            end else begin
               // A new key takes the lowest free slot, even with a zero amount.
               update_raw.write_new = 1'b1;
               update_raw.count     = s1_amount_ff;
               rsp_count_in         = s1_amount_ff;
            end
         end
         KIND_TAKE: begin
            if (!lookup.hit) begin
               rsp_status_in = ST_NOT_FOUND;
            end else if (lookup.hit_count < s1_amount_ff) begin
               rsp_status_in = ST_INSUFFICIENT;
            end else begin
               // An entry that drops to zero keeps its slot.
               update_raw.write_hit = 1'b1;
               update_raw.count     = diff;
               rsp_count_in         = diff;
            end
         end
         KIND_QUERY: begin
            if (lookup.hit) begin
               rsp_count_in = lookup.hit_count;
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         KIND_CLEAR: begin
            update_raw.clear = 1'b1;
         end
         default: begin
            update_raw.clear = 1'b0;
         end
      endcase
   end

   // The table changes only when the transaction moves into the result register.
   always_comb begin
      update           = update_raw;
      update.clear     = update_raw.clear && commit;
      update.write_hit = update_raw.write_hit && commit;
      update.write_new = update_raw.write_new && commit;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/kct_checker.sv
// Port-level assertion checker for the keyed counter table, bound to the top level.
`default_nettype none

`include "keyed_counter_table_macros.svh"

module kct_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [kct_pkg::CNT_W-1:0]     rsp_count,
   input wire [kct_pkg::STAT_W-1:0]    rsp_status
);
   import kct_pkg::*;

   // A stalled result holds its value.
   `KCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_count) && $stable(rsp_status))

   // Failed operations report a zero count.
   `KCT_ASSERT_NOW(a_fail_zero, clock, reset,
      rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_INSUFFICIENT ||
                    rsp_status == ST_FULL),
      rsp_count == '0)

   // A saturated add reports the top of the count range.
   `KCT_ASSERT_NOW(a_sat_max, clock, reset,
      rsp_valid && (rsp_status == ST_SATURATED), rsp_count == CNT_MAX)

   // Every accepted transaction is later followed by a valid result.
   `KCT_ASSERT_NOW(a_latency, clock, reset, req_valid && !req_stall, ##2 rsp_valid)

endmodule

bind keyed_counter_table kct_checker u_kct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_count  (rsp_count),
   .rsp_status (rsp_status)
);

`default_nettype wire
